@@ src/jda_pkg.sv @@
// Shared types and constants for the joystick direction autorepeat block.
`timescale 1ns / 1ps

package jda_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_POLLS_PER_READ    = 3'd0;
  localparam logic [2:0] CFG_POLLS_PER_REPEAT  = 3'd1;
  localparam logic [2:0] CFG_INIT_PER_REPEAT   = 3'd2;
  localparam logic [2:0] CFG_LOW_BOUND         = 3'd3;
  localparam logic [2:0] CFG_HIGH_BOUND        = 3'd4;

  // Reset values
  localparam logic [7:0] CENTER_VALUE   = 8'd127;
  localparam logic [7:0] THRESHOLD_SPAN = 8'd60;
  localparam logic [7:0] LOWER_RESET    = CENTER_VALUE - THRESHOLD_SPAN;
  localparam logic [7:0] UPPER_RESET    = CENTER_VALUE + THRESHOLD_SPAN;

  // Position codes
  localparam logic [3:0] POS_CENTER    = 4'd0;
  localparam logic [3:0] POS_UP        = 4'd1;
  localparam logic [3:0] POS_DOWN      = 4'd2;
  localparam logic [3:0] POS_LEFT      = 4'd3;
  localparam logic [3:0] POS_RIGHT     = 4'd4;
  localparam logic [3:0] POS_UPLEFT    = 4'd5;
  localparam logic [3:0] POS_UPRIGHT   = 4'd6;
  localparam logic [3:0] POS_DOWNLEFT  = 4'd7;
  localparam logic [3:0] POS_DOWNRIGHT = 4'd8;

  // Event kinds
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_CHANGE = 2'd1;
  localparam logic [1:0] EV_REPEAT = 2'd2;

  typedef struct packed {
    logic [7:0] polls_per_read;
    logic [7:0] polls_per_repeat;
    logic [7:0] init_per_repeat;
    logic [7:0] low_bound;
    logic [7:0] high_bound;
  } cfg_t;

  typedef struct packed {
    logic [7:0] read_cnt;
    logic [7:0] rep_cnt;
    logic [7:0] fx;
    logic [7:0] fy;
    logic       next_x;
    logic [3:0] held_pos;
    logic [1:0] held_btn;
  } state_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] new_position;
    logic       new_button_zero;
    logic       new_button_one;
    logic [3:0] old_position;
    logic       old_button_zero;
    logic       old_button_one;
  } result_t;

endpackage

@@ src/jda_regs.sv @@
// Configuration register file for the joystick direction autorepeat block.
`timescale 1ns / 1ps

module jda_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [7:0]        wr_data,
  output jda_pkg::cfg_t     cfg,
  output logic              rep_load
);

  jda_pkg::cfg_t cfg_r;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polls_per_read   <= 8'd0;
      cfg_r.polls_per_repeat <= 8'd0;
      cfg_r.init_per_repeat  <= 8'd0;
      cfg_r.low_bound        <= jda_pkg::LOWER_RESET;
      cfg_r.high_bound       <= jda_pkg::UPPER_RESET;
    end else if (wr_en) begin
      case (wr_index)
        jda_pkg::CFG_POLLS_PER_READ:   cfg_r.polls_per_read   <= wr_data;
        jda_pkg::CFG_POLLS_PER_REPEAT: cfg_r.polls_per_repeat <= wr_data;
        jda_pkg::CFG_INIT_PER_REPEAT:  cfg_r.init_per_repeat  <= wr_data;
        jda_pkg::CFG_LOW_BOUND:        cfg_r.low_bound        <= wr_data;
        jda_pkg::CFG_HIGH_BOUND:       cfg_r.high_bound       <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg      = cfg_r;
  // A write of the initial repeat count also loads the repeat countdown
  assign rep_load = wr_en && (wr_index == jda_pkg::CFG_INIT_PER_REPEAT);

endmodule

@@ src/jda_step.sv @@
// Per-tick logic: read pacing, axis filter, position classify and event decision.
`timescale 1ns / 1ps

module jda_step (
  input  jda_pkg::state_t  st,
  input  jda_pkg::cfg_t    cfg,
  input  logic [7:0]       x_sample,
  input  logic [7:0]       y_sample,
  input  logic             button_zero,
  input  logic             button_one,
  output jda_pkg::state_t  st_nxt,
  output jda_pkg::result_t res
);

  logic [7:0] axis_old;
  logic [7:0] sample;
  logic [9:0] sample_x3;
  logic [8:0] axis_sum;
  logic [7:0] axis_new;
  logic [7:0] fx_new;
  logic [7:0] fy_new;
  logic       left, right, up, down;
  logic [3:0] pos;
  logic [1:0] btn;

  // Filter the selected axis: axis/4 + sample*3/4
  assign axis_old  = st.next_x ? st.fx : st.fy;
  assign sample    = st.next_x ? x_sample : y_sample;
  assign sample_x3 = {2'b00, sample} + {1'b0, sample, 1'b0};
  assign axis_sum  = {3'b000, axis_old[7:2]} + {1'b0, sample_x3[9:2]};
  assign axis_new  = axis_sum[7:0];
  assign fx_new    = st.next_x ? axis_new : st.fx;
  assign fy_new    = st.next_x ? st.fy : axis_new;

  // Classify; left and up win over right and down
  assign left  = fx_new < cfg.low_bound;
  assign right = !left && (fx_new > cfg.high_bound);
  assign up    = fy_new < cfg.low_bound;
  assign down  = !up && (fy_new > cfg.high_bound);
  assign btn   = {button_one, button_zero};

  always_comb begin
    case ({up, down, left, right})
      4'b1010: pos = jda_pkg::POS_UPLEFT;
      4'b1001: pos = jda_pkg::POS_UPRIGHT;
      4'b1000: pos = jda_pkg::POS_UP;
      4'b0110: pos = jda_pkg::POS_DOWNLEFT;
      4'b0101: pos = jda_pkg::POS_DOWNRIGHT;
      4'b0100: pos = jda_pkg::POS_DOWN;
      4'b0010: pos = jda_pkg::POS_LEFT;
      4'b0001: pos = jda_pkg::POS_RIGHT;
      default: pos = jda_pkg::POS_CENTER;
    endcase
  end

  // Decide the next state and the result word
  always_comb begin
    st_nxt = st;
    res    = '0;
    if (st.read_cnt != 8'd0) begin
      st_nxt.read_cnt = st.read_cnt - 8'd1;
    end else begin
      st_nxt.read_cnt = cfg.polls_per_read;
      st_nxt.fx       = fx_new;
      st_nxt.fy       = fy_new;
      st_nxt.next_x   = !st.next_x;
      if ((pos != st.held_pos) || (btn != st.held_btn)) begin
        res.event_kind      = jda_pkg::EV_CHANGE;
        res.new_position    = pos;
        res.new_button_zero = btn[0];
        res.new_button_one  = btn[1];
        res.old_position    = st.held_pos;
        res.old_button_zero = st.held_btn[0];
        res.old_button_one  = st.held_btn[1];
        st_nxt.held_pos     = pos;
        st_nxt.held_btn     = btn;
        st_nxt.rep_cnt      = cfg.init_per_repeat;
      end else if (st.rep_cnt == 8'd0) begin
        res.event_kind      = jda_pkg::EV_REPEAT;
        res.new_position    = st.held_pos;
        res.new_button_zero = st.held_btn[0];
        res.new_button_one  = st.held_btn[1];
        res.old_position    = st.held_pos;
        res.old_button_zero = st.held_btn[0];
        res.old_button_one  = st.held_btn[1];
        st_nxt.rep_cnt      = cfg.polls_per_repeat;
      end else begin
        st_nxt.rep_cnt = st.rep_cnt - 8'd1;
      end
    end
  end

endmodule

@@ src/joystick_direction_autorepeat_top.sv @@
// Top level of the joystick direction autorepeat block: input register, state, result register.
// An accepted word sits in the input register until the result register can take its result.
// Throughput: one word per cycle while out_ready holds; the input register frees as the result register takes a word.
// Every accepted word yields exactly one result word (event kind none on idle ticks).
// Reset (rst_n low, synchronous): pipeline empty, registers and tracker state at defaults.
// Configuration writes take effect at once; cfg_ready is always high.
`timescale 1ns / 1ps

module joystick_direction_autorepeat_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_x_sample,
  input  logic [7:0] in_y_sample,
  input  logic       in_button_zero,
  input  logic       in_button_one,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [3:0] out_new_position,
  output logic       out_new_button_zero,
  output logic       out_new_button_one,
  output logic [3:0] out_old_position,
  output logic       out_old_button_zero,
  output logic       out_old_button_one,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  jda_pkg::cfg_t    cfg;
  logic             rep_load;
  jda_pkg::state_t  st_r, st_nxt, st_step;
  jda_pkg::result_t res;
  jda_pkg::result_t out_r;
  logic             out_valid_r;
  logic             s1_valid_r;
  logic [7:0]       s1_x_r, s1_y_r;
  logic             s1_b0_r, s1_b1_r;
  logic             adv;

  assign cfg_ready = 1'b1;

  jda_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .rep_load (rep_load)
  );

  // Advance when the input register holds a word and the result register can take one
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x_r  <= in_x_sample;
      s1_y_r  <= in_y_sample;
      s1_b0_r <= in_button_zero;
      s1_b1_r <= in_button_one;
    end
  end

  jda_step u_step (
    .st          (st_r),
    .cfg         (cfg),
    .x_sample    (s1_x_r),
    .y_sample    (s1_y_r),
    .button_zero (s1_b0_r),
    .button_one  (s1_b1_r),
    .st_nxt      (st_step),
    .res         (res)
  );

  // Select the tracker state update; a config write of the initial count loads the countdown
  always_comb begin
    st_nxt = st_r;
    if (adv) begin
      st_nxt = st_step;
    end
    if (rep_load) begin
      st_nxt.rep_cnt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.read_cnt <= 8'd0;
      st_r.rep_cnt  <= 8'd0;
      st_r.fx       <= jda_pkg::CENTER_VALUE;
      st_r.fy       <= jda_pkg::CENTER_VALUE;
      st_r.next_x   <= 1'b1;
      st_r.held_pos <= jda_pkg::POS_CENTER;
      st_r.held_btn <= 2'b00;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_kind      = out_r.event_kind;
  assign out_new_position    = out_r.new_position;
  assign out_new_button_zero = out_r.new_button_zero;
  assign out_new_button_one  = out_r.new_button_one;
  assign out_old_position    = out_r.old_position;
  assign out_old_button_zero = out_r.old_button_zero;
  assign out_old_button_one  = out_r.old_button_one;

  // An idle tick leaves the axis selection alone
  a_idle_keeps_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (st_r.read_cnt != 8'd0) && !rep_load) |=> $stable(st_r.next_x))
    else $error("axis selection moved on an idle tick");

  // A no-event word carries all-zero fields
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.event_kind == jda_pkg::EV_NONE)) |->
    (out_r.new_position == 4'd0 && out_r.old_position == 4'd0 &&
     !out_r.new_button_zero && !out_r.new_button_one &&
     !out_r.old_button_zero && !out_r.old_button_one))
    else $error("no-event word has nonzero fields");

  // A repeat word reports the held state as both old and new
  a_repeat_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.event_kind == jda_pkg::EV_REPEAT)) |->
    (out_r.new_position == out_r.old_position &&
     out_r.new_button_zero == out_r.old_button_zero &&
     out_r.new_button_one == out_r.old_button_one))
    else $error("repeat word old and new differ");

  // A change word really changes something
  a_change_differs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.event_kind == jda_pkg::EV_CHANGE)) |->
    (out_r.new_position != out_r.old_position ||
     out_r.new_button_zero != out_r.old_button_zero ||
     out_r.new_button_one != out_r.old_button_one))
    else $error("change word without a change");

  // The held position stays a valid 9-way code
  a_held_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.held_pos <= jda_pkg::POS_DOWNRIGHT)
    else $error("held position out of range");

endmodule

@@ sim/tb.sv @@
// Testbench for the joystick direction autorepeat block: directed tests, then randomized phases.
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CFG_LAST_UNUSED  = 3'd7;
  localparam int         LONG_HOLD_CYCLES = 60;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_x_sample;
  logic [7:0] in_y_sample;
  logic       in_button_zero;
  logic       in_button_one;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_event_kind;
  logic [3:0] out_new_position;
  logic       out_new_button_zero;
  logic       out_new_button_one;
  logic [3:0] out_old_position;
  logic       out_old_button_zero;
  logic       out_old_button_one;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [8-1:0] cfg_data;

  // Predictor copy of the registers and the tracker state
  jda_pkg::cfg_t    model_regs;
  jda_pkg::state_t  tracker;
  jda_pkg::result_t pending_events[$];

  int  error_count;
  bit  tick_offered;
  bit  cfg_offered;
  bit  sender_gaps;
  bit  receiver_stalls;
  bit  hold_request;
  int  hold_cycles;

  // Held stimulus for the random phases, so unchanged states repeat
  logic [7:0] stick_x;
  logic [7:0] stick_y;
  logic [1:0] stick_buttons;

  joystick_direction_autorepeat_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_x_sample         (in_x_sample),
    .in_y_sample         (in_y_sample),
    .in_button_zero      (in_button_zero),
    .in_button_one       (in_button_one),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_kind      (out_event_kind),
    .out_new_position    (out_new_position),
    .out_new_button_zero (out_new_button_zero),
    .out_new_button_one  (out_new_button_one),
    .out_old_position    (out_old_position),
    .out_old_button_zero (out_old_button_zero),
    .out_old_button_one  (out_old_button_one),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void apply_register(logic [2:0] idx, logic [7:0] data);
    case (idx)
      jda_pkg::CFG_POLLS_PER_READ:   model_regs.polls_per_read = data;
      jda_pkg::CFG_POLLS_PER_REPEAT: model_regs.polls_per_repeat = data;
      jda_pkg::CFG_INIT_PER_REPEAT: begin
        model_regs.init_per_repeat = data;
        tracker.rep_cnt = data;
      end
      jda_pkg::CFG_LOW_BOUND:        model_regs.low_bound = data;
      jda_pkg::CFG_HIGH_BOUND:       model_regs.high_bound = data;
      default: ;
    endcase
  endfunction

  // axis/4 + sample*3/4, both truncating; never exceeds 254
  function automatic logic [7:0] smooth_axis(logic [7:0] axis, logic [7:0] sample);
    logic [9:0] sum;
    sum = {4'd0, axis[7:2]} + (({2'b00, sample} * 10'd3) >> 2);
    return sum[7:0];
  endfunction

  // Left and up win over right and down when the thresholds cross
  function automatic logic [3:0] locate_stick(logic [7:0] fx, logic [7:0] fy);
    logic go_left;
    logic go_right;
    go_left  = fx < model_regs.low_bound;
    go_right = !go_left && (fx > model_regs.high_bound);
    if (fy < model_regs.low_bound) begin
      return go_left ? jda_pkg::POS_UPLEFT : go_right ? jda_pkg::POS_UPRIGHT : jda_pkg::POS_UP;
    end
    if (fy > model_regs.high_bound) begin
      return go_left ? jda_pkg::POS_DOWNLEFT :
             go_right ? jda_pkg::POS_DOWNRIGHT : jda_pkg::POS_DOWN;
    end
    return go_left ? jda_pkg::POS_LEFT : go_right ? jda_pkg::POS_RIGHT : jda_pkg::POS_CENTER;
  endfunction

  function automatic jda_pkg::result_t predict_tick(logic [7:0] x, logic [7:0] y,
                                                    logic b0, logic b1);
    jda_pkg::result_t ev;
    logic [3:0]       pos;
    logic [1:0]       btn;
    ev = '0;
    // idle tick: count down, buttons ignored
    if (tracker.read_cnt != 8'd0) begin
      tracker.read_cnt = tracker.read_cnt - 8'd1;
      return ev;
    end
    tracker.read_cnt = model_regs.polls_per_read;
    if (tracker.next_x) begin
      tracker.fx = smooth_axis(tracker.fx, x);
    end else begin
      tracker.fy = smooth_axis(tracker.fy, y);
    end
    tracker.next_x = !tracker.next_x;
    pos = locate_stick(tracker.fx, tracker.fy);
    btn = {b1, b0};
    if (pos != tracker.held_pos || btn != tracker.held_btn) begin
      ev.event_kind      = jda_pkg::EV_CHANGE;
      ev.new_position    = pos;
      ev.new_button_zero = b0;
      ev.new_button_one  = b1;
      ev.old_position    = tracker.held_pos;
      ev.old_button_zero = tracker.held_btn[0];
      ev.old_button_one  = tracker.held_btn[1];
      tracker.held_pos   = pos;
      tracker.held_btn   = btn;
      tracker.rep_cnt    = model_regs.init_per_repeat;
    end else if (tracker.rep_cnt == 8'd0) begin
      ev.event_kind      = jda_pkg::EV_REPEAT;
      ev.new_position    = tracker.held_pos;
      ev.new_button_zero = tracker.held_btn[0];
      ev.new_button_one  = tracker.held_btn[1];
      ev.old_position    = tracker.held_pos;
      ev.old_button_zero = tracker.held_btn[0];
      ev.old_button_one  = tracker.held_btn[1];
      tracker.rep_cnt    = model_regs.polls_per_repeat;
    end else begin
      tracker.rep_cnt = tracker.rep_cnt - 8'd1;
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Match each accepted result word against the oldest prediction
  always @(posedge clk) begin : check_results
    jda_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("result word with no prediction waiting");
        error_count++;
      end else begin
        want = pending_events.pop_front();
        compare_field("event_kind", int'(want.event_kind), int'(out_event_kind));
        compare_field("new_position", int'(want.new_position), int'(out_new_position));
        compare_field("new_button_zero", int'(want.new_button_zero),
                      int'(out_new_button_zero));
        compare_field("new_button_one", int'(want.new_button_one),
                      int'(out_new_button_one));
        compare_field("old_position", int'(want.old_position), int'(out_old_position));
        compare_field("old_button_zero", int'(want.old_button_zero),
                      int'(out_old_button_zero));
        compare_field("old_button_one", int'(want.old_button_one),
                      int'(out_old_button_one));
      end
    end
  end

  // Drive out_ready: long hold on request, short random stalls otherwise
  initial begin
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < LONG_HOLD_CYCLES; hold_cycles++) begin
          @(posedge clk);
        end
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic drop_offers();
    if (tick_offered) begin
      in_valid <= 1'b0;
      tick_offered = 1'b0;
    end
    if (cfg_offered) begin
      cfg_valid <= 1'b0;
      cfg_offered = 1'b0;
    end
  endtask

  // Offer one poll word and record its prediction once accepted
  task automatic send_tick(input logic [7:0] x, input logic [7:0] y,
                           input logic b0, input logic b1);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (cfg_offered) begin
      cfg_valid <= 1'b0;
      cfg_offered = 1'b0;
    end
    if (gap > 0) begin
      if (tick_offered) begin
        in_valid <= 1'b0;
        tick_offered = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_x_sample    <= x;
    in_y_sample    <= y;
    in_button_zero <= b0;
    in_button_one  <= b1;
    tick_offered = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_events.push_back(predict_tick(x, y, b0, b1));
  endtask

  task automatic wait_for_results();
    drop_offers();
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // Write one register once the block has gone idle
  task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
    if (tick_offered) begin
      in_valid <= 1'b0;
      tick_offered = 1'b0;
    end
    while (pending_events.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_offered = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
  endtask

  task automatic load_settings(input logic [7:0] per_read, input logic [7:0] per_repeat,
                               input logic [7:0] first_repeat, input logic [7:0] lower,
                               input logic [7:0] upper);
    write_register(jda_pkg::CFG_POLLS_PER_READ, per_read);
    write_register(jda_pkg::CFG_POLLS_PER_REPEAT, per_repeat);
    write_register(jda_pkg::CFG_INIT_PER_REPEAT, first_repeat);
    write_register(jda_pkg::CFG_LOW_BOUND, lower);
    write_register(jda_pkg::CFG_HIGH_BOUND, upper);
  endtask

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random poll words; the stick mostly holds still so repeats show up
  task automatic drive_random_ticks(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
        stick_x = pick_sample();
      end else if (roll < 4) begin
        stick_y = pick_sample();
      end else if (roll == 4) begin
        stick_buttons = 2'($urandom_range(0, 3));
      end
      send_tick(stick_x, stick_y, stick_buttons[0], stick_buttons[1]);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reset settings: every tick reads an axis, repeats on every unchanged read
  task automatic test_reset_defaults();
    send_tick(8'd0, 8'd0, 1'b0, 1'b0);
    send_tick(8'd0, 8'd0, 1'b1, 1'b0);
    send_tick(8'd255, 8'd255, 1'b0, 1'b1);
    send_tick(8'd255, 8'd255, 1'b1, 1'b1);
    send_tick(8'd255, 8'd255, 1'b1, 1'b1);
    send_tick(8'd127, 8'd127, 1'b0, 1'b0);
  endtask

  // Buttons on skipped polls must not matter
  task automatic test_idle_ticks();
    write_register(jda_pkg::CFG_POLLS_PER_READ, 8'd2);
    send_tick(8'd0, 8'd255, 1'b1, 1'b0);
    send_tick(8'd0, 8'd255, 1'b0, 1'b1);
    send_tick(8'd0, 8'd255, 1'b1, 1'b1);
    send_tick(8'd255, 8'd0, 1'b0, 1'b0);
    send_tick(8'd255, 8'd0, 1'b1, 1'b1);
    send_tick(8'd255, 8'd0, 1'b0, 1'b1);
  endtask

  // First repeat after the initial count, later ones at the shorter pace
  task automatic test_repeat_pacing();
    write_register(jda_pkg::CFG_POLLS_PER_READ, 8'd0);
    write_register(jda_pkg::CFG_POLLS_PER_REPEAT, 8'd2);
    write_register(jda_pkg::CFG_INIT_PER_REPEAT, 8'd3);
    repeat (8) send_tick(8'd127, 8'd127, 1'b0, 1'b0);
  endtask

  // Lower threshold above upper: left and up take precedence
  task automatic test_crossed_thresholds();
    write_register(jda_pkg::CFG_LOW_BOUND, 8'd200);
    write_register(jda_pkg::CFG_HIGH_BOUND, 8'd50);
    send_tick(8'd100, 8'd100, 1'b0, 1'b0);
    send_tick(8'd100, 8'd100, 1'b0, 1'b0);
    send_tick(8'd255, 8'd255, 1'b0, 1'b0);
    send_tick(8'd255, 8'd255, 1'b0, 1'b0);
  endtask

  // Writes past the last register are dropped
  task automatic test_unused_registers();
    for (int idx = CFG_FIRST_UNUSED; idx <= CFG_LAST_UNUSED; idx++) begin
      write_register(idx[2:0], 8'hFF);
    end
    send_tick(8'd40, 8'd200, 1'b1, 1'b0);
    send_tick(8'd40, 8'd200, 1'b1, 1'b0);
  endtask

  task automatic test_random_settings();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    load_settings(8'd0, 8'd0, 8'd0, jda_pkg::LOWER_RESET, jda_pkg::UPPER_RESET);
    drive_random_ticks(200);
    load_settings(8'd1, 8'd2, 8'd4, 8'd100, 8'd150);
    drive_random_ticks(200);
    load_settings(8'd0, 8'd255, 8'd255, 8'd0, 8'd255);
    drive_random_ticks(120);
    load_settings(8'd255, 8'd0, 8'd0, 8'd255, 8'd0);
    drive_random_ticks(300);
    repeat (4) begin
      load_settings(8'($urandom_range(0, 3)), 8'($urandom_range(0, 7)),
                    8'($urandom_range(0, 7)), 8'($urandom_range(30, 127)),
                    8'($urandom_range(128, 230)));
      drive_random_ticks(150);
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    load_settings(8'd0, 8'd1, 8'd1, jda_pkg::LOWER_RESET, jda_pkg::UPPER_RESET);
    hold_request = 1'b1;
    drive_random_ticks(20);
  endtask

  // Closing stretch with both sides running flat out
  task automatic test_full_rate();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    load_settings(8'd0, 8'd1, 8'd3, jda_pkg::LOWER_RESET, jda_pkg::UPPER_RESET);
    drive_random_ticks(150);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_x_sample     = 8'd0;
    in_y_sample     = 8'd0;
    in_button_zero  = 1'b0;
    in_button_one   = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = jda_pkg::CFG_POLLS_PER_READ;
    cfg_data        = 8'd0;
    error_count     = 0;
    tick_offered    = 1'b0;
    cfg_offered     = 1'b0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_request    = 1'b0;
    stick_x         = jda_pkg::CENTER_VALUE;
    stick_y         = jda_pkg::CENTER_VALUE;
    stick_buttons   = 2'b00;

    model_regs.polls_per_read   = 8'd0;
    model_regs.polls_per_repeat = 8'd0;
    model_regs.init_per_repeat  = 8'd0;
    model_regs.low_bound        = jda_pkg::LOWER_RESET;
    model_regs.high_bound       = jda_pkg::UPPER_RESET;
    tracker.read_cnt = 8'd0;
    tracker.rep_cnt  = 8'd0;
    tracker.fx       = jda_pkg::CENTER_VALUE;
    tracker.fy       = jda_pkg::CENTER_VALUE;
    tracker.next_x   = 1'b1;
    tracker.held_pos = jda_pkg::POS_CENTER;
    tracker.held_btn = 2'b00;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_idle_ticks();
    test_repeat_pacing();
    test_crossed_thresholds();
    test_unused_registers();
    test_random_settings();
    test_output_backpressure();
    test_full_rate();

    // Drain, then let the clock run on so that any stray word shows
    wait_for_results();
    repeat (5) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d predicted result words never arrived", pending_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/jda_pkg.sv
src/jda_regs.sv
src/jda_step.sv
src/joystick_direction_autorepeat_top.sv
sim/tb.sv
